// File: sv/u2a_pkg.sv
// shared types, constants and the latin-1 folding table of the utf-8 transliterator
`default_nettype none

package u2a_pkg;

  localparam int unsigned LengthLimit = 1023;
  localparam int unsigned CharW       = 7;
  localparam int unsigned LimitW      = 10;
  localparam int unsigned Slots       = 5;
  localparam int unsigned CharSlots   = 4;

  localparam logic [LimitW-1:0] LimitCap =
      (LengthLimit > 1023) ? 10'd1023 : LimitW'(LengthLimit);
  localparam logic [LimitW-1:0] MaxCharsReset = 10'd30;

  localparam logic [CharW-1:0] Qmark = 7'h3F;

  typedef enum logic [1:0] {
    SeqNone  = 2'd0,
    SeqTwo   = 2'd1,
    SeqThree = 2'd2,
    SeqFour  = 2'd3
  } seq_kind_e;

  typedef struct packed {
    logic             eon;
    logic [CharW-1:0] ch;
  } result_t;

  function automatic logic [CharW-1:0] latin1_fold(input logic [7:0] c);
    logic [CharW-1:0] r;
    r = Qmark;
    if (!c[7]) begin
      r = (c == 8'h00) ? Qmark : c[6:0];
    end else begin
      case (c)
        8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5,
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5: r = 7'h61;
        8'hC7, 8'hE7:                             r = 7'h63;
        8'hC8, 8'hC9, 8'hCA, 8'hCB,
        8'hE8, 8'hE9, 8'hEA, 8'hEB:               r = 7'h65;
        8'hCC, 8'hCD, 8'hCE, 8'hCF,
        8'hEC, 8'hED, 8'hEE, 8'hEF:               r = 7'h69;
        8'hD1, 8'hF1:                             r = 7'h6E;
        8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6,
        8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6:        r = 7'h6F;
        8'hD9, 8'hDA, 8'hDB, 8'hDC,
        8'hF9, 8'hFA, 8'hFB, 8'hFC:               r = 7'h75;
        8'hDD, 8'hFD, 8'hFF:                      r = 7'h79;
        default:                                  r = Qmark;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/utf8_to_ascii_transliterator_unit.sv
// utf-8 name to ascii display transliterator, top level
//
// Bytes of a name enter on the s_axis side, one word per cycle while tready is
// high, with tlast on the final byte. Each accepted byte is decoded into a
// batch of up to five result words (folded characters, then the NUL terminator
// with tlast after the final byte), which then drains one word per cycle while
// the output is not stalled, through an output register. A byte that gives at
// most one word sustains one byte per cycle while the output is not stalled; a
// byte whose batch has more words (it breaks off a pending sequence or ends the
// name) holds the input until its batch has drained to the last word. The character
// limit (max_chars, reset 30) must be written through the cfg channel while the
// block is idle, which it does not enforce; the terminator is always sent.
`default_nettype none

module utf8_to_ascii_transliterator_unit import u2a_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // text_byte
  input  wire logic              s_axis_tlast,   // is_last
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output      logic [7:0]        m_axis_tdata,   // ascii_char, zero fill
  output      logic              m_axis_tlast,   // end_of_name
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [LimitW-1:0] cfg_wdata_i     // max_chars
);

  // decoder state
  logic [LimitW-1:0] max_chars_q;
  logic [7:0]        lead_q, lead_d;
  seq_kind_e         kind_q, kind_d;
  logic [1:0]        seen_q, seen_d;
  logic [LimitW-1:0] cnt_q, cnt_d;

  // batch and output register
  result_t           slot_q [Slots];
  result_t           slot_d [Slots];
  logic [2:0]        left_q, left_d;
  logic              out_valid_q;
  result_t           out_q;

  logic              accept, out_free, move;

  // decode
  logic [7:0]        b;
  logic              is_cont, case_a, complete, p2, last;
  seq_kind_e         fresh_kind, mid_kind;
  logic [1:0]        seen_inc, mid_seen;
  logic [7:0]        mid_lead;
  logic [10:0]       cp;
  logic [CharW-1:0]  two_char, p2_char, lead_char, mid_char;
  logic [2:0]        n1, n3, ntot, emitted, p2_pos, n3_pos;
  logic [LimitW-1:0] limit, room;
  logic [CharW-1:0]  ch [CharSlots];

  assign cfg_ready_o = 1'b1;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign move          = (left_q != 3'd0) && out_free;
  assign s_axis_tready = (left_q == 3'd0) || ((left_q == 3'd1) && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.ch};
  assign m_axis_tlast  = out_q.eon;

  always_comb begin
    b       = s_axis_tdata;
    last    = s_axis_tlast;
    is_cont = (b[7:6] == 2'b10);

    if (b[7:5] == 3'b110) begin
      fresh_kind = SeqTwo;
    end else if (b[7:4] == 4'b1110) begin
      fresh_kind = SeqThree;
    end else if (b[7:3] == 5'b11110) begin
      fresh_kind = SeqFour;
    end else begin
      fresh_kind = SeqNone;
    end

    case_a   = (kind_q != SeqNone) && is_cont;
    seen_inc = seen_q + 2'd1;
    complete = case_a && (seen_inc >= 2'(kind_q));

    cp       = {lead_q[4:0], b[5:0]};
    two_char = ((cp > 11'h0FF) || (cp < 11'h080)) ? Qmark : latin1_fold(cp[7:0]);
    p2_char  = case_a ? ((kind_q == SeqTwo) ? two_char : Qmark) : latin1_fold(b);
    p2       = case_a ? complete : (fresh_kind == SeqNone);

    n1        = (!case_a && (kind_q != SeqNone)) ? (3'd1 + {1'b0, seen_q}) : 3'd0;
    lead_char = latin1_fold(lead_q);

    if (case_a) begin
      mid_kind = complete ? SeqNone : kind_q;
      mid_seen = complete ? 2'd0 : seen_inc;
      mid_lead = lead_q;
    end else begin
      mid_kind = fresh_kind;
      mid_seen = 2'd0;
      mid_lead = b;
    end
    mid_char = latin1_fold(mid_lead);

    n3     = (last && (mid_kind != SeqNone)) ? (3'd1 + {1'b0, mid_seen}) : 3'd0;
    p2_pos = n1;
    n3_pos = n1 + {2'b00, p2};
    ntot   = n1 + {2'b00, p2} + n3;

    for (int i = 0; i < CharSlots; i++) begin
      ch[i] = Qmark;
      if ((n1 != 3'd0) && (i == 0)) begin
        ch[i] = lead_char;
      end
      if (p2 && (p2_pos == 3'(i))) begin
        ch[i] = p2_char;
      end
      if ((n3 != 3'd0) && (n3_pos == 3'(i))) begin
        ch[i] = mid_char;
      end
    end

    limit   = (max_chars_q < LimitCap) ? max_chars_q : LimitCap;
    room    = (cnt_q >= limit) ? '0 : (limit - cnt_q);
    emitted = (room < {7'd0, ntot}) ? room[2:0] : ntot;

    for (int i = 0; i < CharSlots; i++) begin
      if (3'(i) < emitted) begin
        slot_d[i] = '{eon: 1'b0, ch: ch[i]};
      end else if ((3'(i) == emitted) && last) begin
        slot_d[i] = '{eon: 1'b1, ch: '0};
      end else begin
        slot_d[i] = '{eon: 1'b0, ch: '0};
      end
    end
    slot_d[Slots-1] = '{eon: last, ch: '0};

    left_d = emitted + {2'b00, last};

    if (last) begin
      kind_d = SeqNone;
      seen_d = 2'd0;
      lead_d = 8'd0;
      cnt_d  = '0;
    end else begin
      kind_d = mid_kind;
      seen_d = mid_seen;
      lead_d = mid_lead;
      cnt_d  = cnt_q + {7'd0, emitted};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxCharsReset;
      lead_q      <= 8'd0;
      kind_q      <= SeqNone;
      seen_q      <= 2'd0;
      cnt_q       <= '0;
      left_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_chars_q <= cfg_wdata_i;
      end
      if (accept) begin
        lead_q <= lead_d;
        kind_q <= kind_d;
        seen_q <= seen_d;
        cnt_q  <= cnt_d;
        left_q <= left_d;
      end else if (move) begin
        left_q <= left_q - 3'd1;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // batch shifts down one word per drain
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < Slots; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end else if (move) begin
      for (int i = 0; i < Slots - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
    if (move) begin
      out_q <= slot_q[0];
    end
  end

endmodule

`default_nettype wire
